[rtl/ahpc_pkg.sv]
// Shared constants, types and state codes for the average hash pair compare unit.
`default_nettype none

package ahpc_pkg;

   // Field widths fixed by the interface.
   localparam int PIXEL_W       = 8;
   localparam int SUM_W         = 14;
   localparam int DIST_W        = 7;
   localparam int THRESH_W      = 7;
   localparam int HASH_OUT_W    = 64;
   localparam int HASH_BITS_DEF = 64;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd11;

   // Controller states: load pixels, scan the stores, push the result.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_PUSH
   } state_type;

   // Strobes from the controller to each hash lane.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic shift_en;
      logic in_range;
      logic clear_sum;
   } lane_ctrl_type;

endpackage

`default_nettype wire

[rtl/average_hash_pair_compare_unit.sv]
// Top level of the average hash pair compare unit.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_pixel_a, req_pixel_b, req_last_pixel
//   rsp      out        rsp_valid / rsp_stall  rsp_hash_a, rsp_hash_b, rsp_distance,
//                                              rsp_is_match
//   csr      in         csr_valid / csr_ready  csr_match_threshold
//
// Pixel pair requests are taken without stall while loading a frame.
// The frame end starts a scan: the stores are read one entry per cycle and
// each hash gets one bit per cycle, then the push state moves the result
// into the output register. A waiting result does not block loading of the
// next frame; a stalled result holds only the push of the next one. Reset is
// synchronous; threshold resets to 11.
`default_nettype none

module average_hash_pair_compare_unit #(
   parameter int HASH_BITS = ahpc_pkg::HASH_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire [ahpc_pkg::PIXEL_W-1:0]          req_pixel_a,
   input  wire [ahpc_pkg::PIXEL_W-1:0]          req_pixel_b,
   input  wire                                  req_last_pixel,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [ahpc_pkg::HASH_OUT_W-1:0]      rsp_hash_a,
   output logic [ahpc_pkg::HASH_OUT_W-1:0]      rsp_hash_b,
   output logic [ahpc_pkg::DIST_W-1:0]          rsp_distance,
   output logic                                 rsp_is_match,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [ahpc_pkg::THRESH_W-1:0]         csr_match_threshold
);

   localparam int IdxW = $clog2(HASH_BITS);
   localparam int OutW = ahpc_pkg::HASH_OUT_W;

   ahpc_pkg::lane_ctrl_type lane_ctrl;
   logic [IdxW-1:0]         wr_addr;
   logic [IdxW-1:0]         rd_addr;
   logic [IdxW:0]           frame_len;
   logic                    cmp_bit_a, cmp_bit_b;
   logic [HASH_BITS-1:0]    hash_a, hash_b;
   logic [HASH_BITS-1:0]    out_hash_a, out_hash_b;

   // The threshold register accepts a write in any cycle.
   assign csr_ready = 1'b1;

   ahpc_ctrl #(
      .HASH_BITS(HASH_BITS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_last_pixel      (req_last_pixel),
      .csr_valid           (csr_valid),
      .csr_match_threshold (csr_match_threshold),
      .lane_ctrl           (lane_ctrl),
      .wr_addr             (wr_addr),
      .rd_addr             (rd_addr),
      .frame_len           (frame_len),
      .cmp_bit_a           (cmp_bit_a),
      .cmp_bit_b           (cmp_bit_b),
      .hash_a              (hash_a),
      .hash_b              (hash_b),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hash_a          (out_hash_a),
      .rsp_hash_b          (out_hash_b),
      .rsp_distance        (rsp_distance),
      .rsp_is_match        (rsp_is_match)
   );

   // First image lane.
   ahpc_hash_lane #(
      .HASH_BITS(HASH_BITS)
   ) u_lane_a (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .wr_addr   (wr_addr),
      .wr_pixel  (req_pixel_a),
      .rd_addr   (rd_addr),
      .frame_len (frame_len),
      .cmp_bit   (cmp_bit_a),
      .hash      (hash_a)
   );

   // Second image lane.
   ahpc_hash_lane #(
      .HASH_BITS(HASH_BITS)
   ) u_lane_b (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .wr_addr   (wr_addr),
      .wr_pixel  (req_pixel_b),
      .rd_addr   (rd_addr),
      .frame_len (frame_len),
      .cmp_bit   (cmp_bit_b),
      .hash      (hash_b)
   );

   // Hash bits above HASH_BITS read as zero.
   assign rsp_hash_a = OutW'(out_hash_a);
   assign rsp_hash_b = OutW'(out_hash_b);

endmodule

`default_nettype wire

[rtl/ahpc_hash_lane.sv]
// One image lane: pixel store, running sum, mean compare and hash shift register.
`default_nettype none

module ahpc_hash_lane #(
   parameter int HASH_BITS = ahpc_pkg::HASH_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire ahpc_pkg::lane_ctrl_type         ctrl,
   input  wire [$clog2(HASH_BITS)-1:0]          wr_addr,
   input  wire [ahpc_pkg::PIXEL_W-1:0]          wr_pixel,
   input  wire [$clog2(HASH_BITS)-1:0]          rd_addr,
   input  wire [$clog2(HASH_BITS):0]            frame_len,
   output logic                                 cmp_bit,
   output logic [HASH_BITS-1:0]                 hash
);

   localparam int IdxW  = $clog2(HASH_BITS);
   localparam int ProdW = ahpc_pkg::PIXEL_W + IdxW + 1;
   localparam int CmpW  = (ProdW > ahpc_pkg::SUM_W) ? ProdW : ahpc_pkg::SUM_W;

   logic [ahpc_pkg::PIXEL_W-1:0] store_mem [HASH_BITS];
   logic [ahpc_pkg::PIXEL_W-1:0] rd_data_ff;
   logic [ahpc_pkg::SUM_W-1:0]   sum_ff;
   logic [ahpc_pkg::SUM_W-1:0]   sum_in;
   logic [HASH_BITS-1:0]         hash_ff;
   logic [ProdW-1:0]             product;

   // Pixel store with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         store_mem[wr_addr] <= wr_pixel;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Running sum wraps at its register width and clears after each frame.
   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear_sum) begin
         sum_in = '0;
      end else if (ctrl.wr_en) begin
         sum_in = sum_ff + ahpc_pkg::SUM_W'(wr_pixel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // Pixel is above the mean when pixel times frame length exceeds the sum.
   assign product = ProdW'(rd_data_ff) * ProdW'(frame_len);
   assign cmp_bit = ctrl.in_range && (CmpW'(product) > CmpW'(sum_ff));

   // Hash bits enter at the top, so after a full pass bit i belongs to pixel i.
   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         hash_ff <= {cmp_bit, hash_ff[HASH_BITS-1:1]};
      end
   end

   assign hash = hash_ff;

endmodule

`default_nettype wire

[rtl/ahpc_ctrl.sv]
// Sequencer: pixel counting, store scan, distance count and result register.
`default_nettype none

module ahpc_ctrl #(
   parameter int HASH_BITS = ahpc_pkg::HASH_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request side.
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_last_pixel,
   // Threshold register write.
   input  wire                                  csr_valid,
   input  wire [ahpc_pkg::THRESH_W-1:0]         csr_match_threshold,
   // Lane control.
   output ahpc_pkg::lane_ctrl_type              lane_ctrl,
   output logic [$clog2(HASH_BITS)-1:0]         wr_addr,
   output logic [$clog2(HASH_BITS)-1:0]         rd_addr,
   output logic [$clog2(HASH_BITS):0]           frame_len,
   input  wire                                  cmp_bit_a,
   input  wire                                  cmp_bit_b,
   input  wire [HASH_BITS-1:0]                  hash_a,
   input  wire [HASH_BITS-1:0]                  hash_b,
   // Result side.
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [HASH_BITS-1:0]                 rsp_hash_a,
   output logic [HASH_BITS-1:0]                 rsp_hash_b,
   output logic [ahpc_pkg::DIST_W-1:0]          rsp_distance,
   output logic                                 rsp_is_match
);

   localparam int IdxW = $clog2(HASH_BITS);
   localparam int CntW = IdxW + 1;

   ahpc_pkg::state_type          state_ff, state_in;
   logic [IdxW-1:0]              pos_ff, pos_in;
   logic [CntW-1:0]              len_ff, len_in;
   logic [CntW-1:0]              scan_cnt_ff, scan_cnt_in;
   logic [IdxW-1:0]              cmp_idx_ff;
   logic                         cmp_valid_ff;
   logic [ahpc_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [ahpc_pkg::THRESH_W-1:0] thresh_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [HASH_BITS-1:0]         out_hash_a_ff, out_hash_b_ff;
   logic [ahpc_pkg::DIST_W-1:0]  out_dist_ff;
   logic                         out_match_ff;

   logic accept, frame_end, scan_issue, scan_done, push, rsp_taken;

   assign accept     = req_valid && !req_stall;
   assign frame_end  = req_last_pixel || (pos_ff == IdxW'(HASH_BITS - 1));
   assign scan_done  = (scan_cnt_ff == CntW'(HASH_BITS));
   assign rsp_taken  = rsp_valid_ff && !rsp_stall;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ahpc_pkg::ST_LOAD: begin
            if (req_valid && frame_end) begin
               state_in = ahpc_pkg::ST_SCAN;
            end
         end
         ahpc_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = ahpc_pkg::ST_PUSH;
            end
         end
         ahpc_pkg::ST_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ahpc_pkg::ST_LOAD;
            end
         end
         default: state_in = ahpc_pkg::ST_LOAD;
      endcase
   end

   // State-dependent outputs and strobes.
   always_comb begin
      req_stall  = 1'b1;
      scan_issue = 1'b0;
      push       = 1'b0;
      case (state_ff)
         ahpc_pkg::ST_LOAD: req_stall  = 1'b0;
         ahpc_pkg::ST_SCAN: scan_issue = !scan_done;
         ahpc_pkg::ST_PUSH: push       = !rsp_valid_ff || !rsp_stall;
         default:           req_stall  = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ahpc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pixel position and frame length; the frame ends on the mark or a full store.
   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      if (accept) begin
         if (frame_end) begin
            pos_in = '0;
            len_in = CntW'(pos_ff) + CntW'(1);
         end else begin
            pos_in = pos_ff + IdxW'(1);
         end
      end
   end

   // Scan counter issues one store read per cycle; the compare follows in the next cycle.
   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (accept && frame_end) begin
         scan_cnt_in = '0;
      end else if (scan_issue) begin
         scan_cnt_in = scan_cnt_ff + CntW'(1);
      end
   end

   // Distance counts differing hash bits as they leave the compare.
   always_comb begin
      dist_in = dist_ff;
      if (accept && frame_end) begin
         dist_in = '0;
      end else if (cmp_valid_ff && (cmp_bit_a != cmp_bit_b)) begin
         dist_in = dist_ff + ahpc_pkg::DIST_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         len_ff       <= '0;
         scan_cnt_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         dist_ff      <= '0;
      end else begin
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         scan_cnt_ff  <= scan_cnt_in;
         cmp_valid_ff <= scan_issue;
         dist_ff      <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_issue) begin
         cmp_idx_ff <= scan_cnt_ff[IdxW-1:0];
      end
   end

   // Threshold register; writes are always taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ahpc_pkg::THRESH_RESET;
      end else if (csr_valid) begin
         thresh_ff <= csr_match_threshold;
      end
   end

   // Result register frees the lanes for the next frame while it waits.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_hash_a_ff <= hash_a;
         out_hash_b_ff <= hash_b;
         out_dist_ff   <= dist_ff;
         out_match_ff  <= (dist_ff <= thresh_ff);
      end
   end

   // Lane strobes.
   always_comb begin
      lane_ctrl.wr_en     = accept;
      lane_ctrl.rd_en     = scan_issue;
      lane_ctrl.shift_en  = cmp_valid_ff;
      lane_ctrl.in_range  = (CntW'(cmp_idx_ff) < len_ff);
      lane_ctrl.clear_sum = push;
   end

   assign wr_addr      = pos_ff;
   assign rd_addr      = scan_cnt_ff[IdxW-1:0];
   assign frame_len    = len_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hash_a   = out_hash_a_ff;
   assign rsp_hash_b   = out_hash_b_ff;
   assign rsp_distance = out_dist_ff;
   assign rsp_is_match = out_match_ff;

endmodule

`default_nettype wire

[verif/average_hash_pair_compare_checker.sv]
// Checker that predicts each frame's hashes, distance and match flag and compares the results.
`timescale 1ns / 1ps

module average_hash_pair_compare_checker #(
   parameter int HASH_BITS = ahpc_pkg::HASH_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_stall,
   input  wire [ahpc_pkg::PIXEL_W-1:0]      req_pixel_a,
   input  wire [ahpc_pkg::PIXEL_W-1:0]      req_pixel_b,
   input  wire                              req_last_pixel,
   input  wire                              rsp_valid,
   input  wire                              rsp_stall,
   input  wire [ahpc_pkg::HASH_OUT_W-1:0]   rsp_hash_a,
   input  wire [ahpc_pkg::HASH_OUT_W-1:0]   rsp_hash_b,
   input  wire [ahpc_pkg::DIST_W-1:0]       rsp_distance,
   input  wire                              rsp_is_match,
   input  wire                              csr_valid,
   input  wire                              csr_ready,
   input  wire [ahpc_pkg::THRESH_W-1:0]     csr_match_threshold,
   output int                               fail_count,
   output int                               awaited_results,
   output int                               results_checked
);

   // One expected frame result.
   typedef struct packed {
      logic [ahpc_pkg::HASH_OUT_W-1:0] hash_a;
      logic [ahpc_pkg::HASH_OUT_W-1:0] hash_b;
      logic [ahpc_pkg::DIST_W-1:0]     distance;
      logic                            is_match;
   } frame_digest_type;

   // Private copy of the block's state.
   logic [ahpc_pkg::PIXEL_W-1:0]  frame_pixels_a [HASH_BITS];
   logic [ahpc_pkg::PIXEL_W-1:0]  frame_pixels_b [HASH_BITS];
   logic [ahpc_pkg::SUM_W-1:0]    frame_sum_a;
   logic [ahpc_pkg::SUM_W-1:0]    frame_sum_b;
   logic [5:0]                    next_position;
   logic [ahpc_pkg::THRESH_W-1:0] match_limit;

   // Results predicted but not yet seen on the output, oldest first.
   frame_digest_type pending_digests [$];

   initial begin
      fail_count      = 0;
      awaited_results = 0;
      results_checked = 0;
   end

   // Prints one line per failure and counts every failure.
   task automatic report_failure(input string line);
      fail_count++;
      $display("%0t ns: %s", $time, line);
   endtask

   // Stores one pixel pair and, at the end of a frame, queues the expected result.
   task automatic absorb_pixel_pair(input logic [ahpc_pkg::PIXEL_W-1:0] pix_a,
                                    input logic [ahpc_pkg::PIXEL_W-1:0] pix_b,
                                    input logic last);
      int position;
      int count;
      int i;
      frame_digest_type digest;
      position = int'(next_position) % HASH_BITS;
      frame_pixels_a[position] = pix_a;
      frame_pixels_b[position] = pix_b;
      frame_sum_a = frame_sum_a + pix_a;
      frame_sum_b = frame_sum_b + pix_b;
      count = position + 1;
      if (!last && count < HASH_BITS) begin
         next_position = 6'(count);
      end else begin
         // A bit is set where the pixel lies strictly above the frame mean.
         digest = '0;
         for (i = 0; i < count; i++) begin
            if (int'(frame_pixels_a[i]) * count > int'(frame_sum_a)) begin
               digest.hash_a[i] = 1'b1;
            end
            if (int'(frame_pixels_b[i]) * count > int'(frame_sum_b)) begin
               digest.hash_b[i] = 1'b1;
            end
         end
         digest.distance = ahpc_pkg::DIST_W'($countones(digest.hash_a ^ digest.hash_b));
         digest.is_match = (digest.distance <= match_limit);
         pending_digests = {pending_digests, digest};
         frame_sum_a   = '0;
         frame_sum_b   = '0;
         next_position = '0;
      end
   endtask

   // Sample every channel at the rising edge.
   always @(posedge clock) begin : watch
      frame_digest_type want;
      if (reset) begin
         frame_sum_a   = '0;
         frame_sum_b   = '0;
         next_position = '0;
         match_limit   = ahpc_pkg::THRESH_RESET;
         pending_digests.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            match_limit = csr_match_threshold;
         end
         // Compare a delivered result with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (pending_digests.size() == 0) begin
               report_failure($sformatf("result with no frame pending: hash_a %h hash_b %h",
                                        rsp_hash_a, rsp_hash_b));
            end else begin
               want = pending_digests.pop_front();
               if (rsp_hash_a !== want.hash_a) begin
                  report_failure($sformatf("hash_a %h, expected %h", rsp_hash_a, want.hash_a));
               end
               if (rsp_hash_b !== want.hash_b) begin
                  report_failure($sformatf("hash_b %h, expected %h", rsp_hash_b, want.hash_b));
               end
               if (rsp_distance !== want.distance) begin
                  report_failure($sformatf("distance %0d, expected %0d",
                                           rsp_distance, want.distance));
               end
               if (rsp_is_match !== want.is_match) begin
                  report_failure($sformatf("is_match %b, expected %b (distance %0d)",
                                           rsp_is_match, want.is_match, want.distance));
               end
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            absorb_pixel_pair(req_pixel_a, req_pixel_b, req_last_pixel);
         end
      end
      awaited_results = pending_digests.size();
   end

endmodule

[verif/average_hash_pair_compare_unit_test.sv]
// Testbench top that drives pixel frames and thresholds into the unit and gives the verdict.
`timescale 1ns / 1ps

module average_hash_pair_compare_unit_test;

   localparam int FRAME_PIXELS    = ahpc_pkg::HASH_BITS_DEF;
   localparam int SETTLE_CYCLES   = FRAME_PIXELS + 16;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_PAIRS     = 140;
   localparam int PHASE_FRAMES    = 4;

   // Content styles for random frames.
   typedef enum int {
      PAT_UNIFORM,
      PAT_SIMILAR,
      PAT_BINARY,
      PAT_FLAT,
      PAT_NARROW
   } pixel_pattern_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [ahpc_pkg::PIXEL_W-1:0]      req_pixel_a;
   logic [ahpc_pkg::PIXEL_W-1:0]      req_pixel_b;
   logic                              req_last_pixel;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [ahpc_pkg::HASH_OUT_W-1:0]   rsp_hash_a;
   logic [ahpc_pkg::HASH_OUT_W-1:0]   rsp_hash_b;
   logic [ahpc_pkg::DIST_W-1:0]       rsp_distance;
   logic                              rsp_is_match;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [ahpc_pkg::THRESH_W-1:0]     csr_match_threshold;

   int   fail_count;
   int   awaited_results;
   int   results_checked;
   int   pairs_sent;
   int   frames_sent;
   int   cycle_count;
   int   middle_threshold;
   logic quiet;
   logic hold_off_now;

   average_hash_pair_compare_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_a         (req_pixel_a),
      .req_pixel_b         (req_pixel_b),
      .req_last_pixel      (req_last_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hash_a          (rsp_hash_a),
      .rsp_hash_b          (rsp_hash_b),
      .rsp_distance        (rsp_distance),
      .rsp_is_match        (rsp_is_match),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_match_threshold (csr_match_threshold)
   );

   average_hash_pair_compare_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel_a         (req_pixel_a),
      .req_pixel_b         (req_pixel_b),
      .req_last_pixel      (req_last_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hash_a          (rsp_hash_a),
      .rsp_hash_b          (rsp_hash_b),
      .rsp_distance        (rsp_distance),
      .rsp_is_match        (rsp_is_match),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_match_threshold (csr_match_threshold),
      .fail_count          (fail_count),
      .awaited_results     (awaited_results),
      .results_checked     (results_checked)
   );

   // Free-running clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit, counted in cycles.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results awaited.",
                     cycle_count, awaited_results);
            $display("[average_hash_pair_compare_unit] ERROR");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request, none when quiet.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_now) begin
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_now = 1'b0;
            rsp_stall    = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Presents one pixel pair request and holds it until it is taken.
   task automatic offer_pixel_pair(input logic [ahpc_pkg::PIXEL_W-1:0] pix_a,
                                   input logic [ahpc_pkg::PIXEL_W-1:0] pix_b,
                                   input logic last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_pixel_a    = pix_a;
      req_pixel_b    = pix_b;
      req_last_pixel = last;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      pairs_sent++;
   endtask

   // Waits for every expected result, then for the scan of a frame to settle.
   task automatic drain_results();
      while (awaited_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the match threshold once the unit is idle.
   task automatic set_match_threshold(input logic [ahpc_pkg::THRESH_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_valid           = 1'b1;
      csr_match_threshold = value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Sends one frame of the given length in a randomly chosen content style.
   task automatic send_frame(input int length, input logic marked);
      pixel_pattern_type pattern;
      int   base;
      int   near;
      int   i;
      logic [ahpc_pkg::PIXEL_W-1:0] pix_a;
      logic [ahpc_pkg::PIXEL_W-1:0] pix_b;
      logic last;
      pattern = pixel_pattern_type'($urandom_range(0, 4));
      base    = $urandom_range(0, 255);
      for (i = 0; i < length; i++) begin
         case (pattern)
            PAT_SIMILAR: begin
               // Second image is the first plus a little noise, so hashes stay close.
               pix_a = ahpc_pkg::PIXEL_W'($urandom_range(0, 255));
               near  = int'(pix_a) + $urandom_range(0, 4) - 2;
               if (near < 0) near = 0;
               if (near > 255) near = 255;
               pix_b = ahpc_pkg::PIXEL_W'(near);
            end
            PAT_BINARY: begin
               pix_a = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
               pix_b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
            PAT_FLAT: begin
               // Mostly one value, which puts many pixels exactly on the mean.
               pix_a = ahpc_pkg::PIXEL_W'(base + (($urandom_range(0, 7) == 0) ? 1 : 0));
               pix_b = ahpc_pkg::PIXEL_W'(base + (($urandom_range(0, 7) == 0) ? 1 : 0));
            end
            PAT_NARROW: begin
               pix_a = ahpc_pkg::PIXEL_W'(base + $urandom_range(0, 3));
               pix_b = ahpc_pkg::PIXEL_W'(base + $urandom_range(0, 3));
            end
            default: begin
               pix_a = ahpc_pkg::PIXEL_W'($urandom_range(0, 255));
               pix_b = ahpc_pkg::PIXEL_W'($urandom_range(0, 255));
            end
         endcase
         last = (i == length - 1) && (length < FRAME_PIXELS || marked);
         offer_pixel_pair(pix_a, pix_b, last);
      end
      frames_sent++;
   endtask

   // Random frames: full frames with or without the end mark, and short marked frames.
   task automatic run_random_phase();
      int start_pairs;
      int start_frames;
      int pick;
      start_pairs  = pairs_sent;
      start_frames = frames_sent;
      while (pairs_sent - start_pairs < PHASE_PAIRS || frames_sent - start_frames < PHASE_FRAMES)
      begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            send_frame(FRAME_PIXELS, $urandom_range(0, 1) != 0);
         end else if (pick == 9) begin
            send_frame($urandom_range(1, FRAME_PIXELS - 1), 1'b1);
         end else begin
            send_frame($urandom_range(1, 16), 1'b1);
         end
      end
   endtask

   // Main sequence.
   initial begin : stimulus
      int i;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_pixel_a         = '0;
      req_pixel_b         = '0;
      req_last_pixel      = 1'b0;
      csr_valid           = 1'b0;
      csr_match_threshold = '0;
      quiet               = 1'b0;
      hold_off_now        = 1'b0;
      pairs_sent          = 0;
      frames_sent         = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed frames at the reset threshold: one-pair frames at the extremes,
      // a two-pair frame, a flat frame where every pixel equals the mean, and a
      // sixteen-pair frame of inverted images whose distance exceeds the threshold.
      offer_pixel_pair(8'd255, 8'd0, 1'b1);
      offer_pixel_pair(8'd0, 8'd255, 1'b1);
      offer_pixel_pair(8'd0, 8'd255, 1'b0);
      offer_pixel_pair(8'd255, 8'd0, 1'b1);
      offer_pixel_pair(8'd128, 8'd128, 1'b0);
      offer_pixel_pair(8'd128, 8'd128, 1'b0);
      offer_pixel_pair(8'd128, 8'd128, 1'b1);
      for (i = 0; i < 16; i++) begin
         offer_pixel_pair((i % 2 == 0) ? 8'd0 : 8'd255, (i % 2 == 0) ? 8'd255 : 8'd0,
                          i == 15);
      end
      frames_sent += 5;

      // Strictest threshold, with a long result hold-off that backs up the input.
      set_match_threshold('0);
      hold_off_now = 1'b1;
      run_random_phase();

      set_match_threshold(ahpc_pkg::THRESH_W'(FRAME_PIXELS));
      run_random_phase();

      // Largest register value: every distance is a match.
      set_match_threshold('1);
      run_random_phase();

      middle_threshold = $urandom_range(1, 63);
      set_match_threshold(ahpc_pkg::THRESH_W'(middle_threshold));
      run_random_phase();

      // Back to the reset value, with no idling on either side.
      set_match_threshold(ahpc_pkg::THRESH_RESET);
      quiet = 1'b1;
      run_random_phase();

      drain_results();
      $display("Covered %0d pixel pairs in %0d frames: short, full, marked and unmarked.",
               pairs_sent, frames_sent);
      $display("Checked %0d results at thresholds 11, 0, 64, 127, %0d and 11 again.",
               results_checked, middle_threshold);
      if (fail_count == 0) begin
         $display("[average_hash_pair_compare_unit] OK");
      end else begin
         $display("[average_hash_pair_compare_unit] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ahpc_pkg.sv
rtl/ahpc_hash_lane.sv
rtl/ahpc_ctrl.sv
rtl/average_hash_pair_compare_unit.sv
verif/average_hash_pair_compare_checker.sv
verif/average_hash_pair_compare_unit_test.sv
